>>> rtl/core/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types, constants and the ln mantissa table for the binned Poisson
// template likelihood block.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int unsigned NumTpl    = 5;
  localparam int unsigned LogDepth  = 256;
  localparam int unsigned LogIdxW   = $clog2(LogDepth);
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned TplW      = 24;
  localparam int unsigned CountW    = 16;
  localparam int unsigned ProdW     = ScaleW + TplW;
  localparam int unsigned PredW     = 24;
  localparam int unsigned LnW       = 22;
  localparam int unsigned AddW      = 34;
  localparam int unsigned SumW      = 56;
  localparam int unsigned UsedW     = 3;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;
  localparam logic [16:0] Ln2Q16    = 17'd45426;
  localparam logic [ScaleW-1:0] ScaleRst = 16'd4096;
  localparam logic [UsedW-1:0]  UsedRst  = 3'd5;

  typedef enum logic [2:0] {
    RegScale0 = 3'd0,
    RegScale1 = 3'd1,
    RegScale2 = 3'd2,
    RegScale3 = 3'd3,
    RegScale4 = 3'd4,
    RegUsed   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] observed_count;
    logic [TplW-1:0]   template_0;
    logic [TplW-1:0]   template_1;
    logic [TplW-1:0]   template_2;
    logic [TplW-1:0]   template_3;
    logic [TplW-1:0]   template_4;
    logic              last_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [SumW-1:0] deviance;
    logic                   saturated;
  } out_item_t;

  // per-stage control carried alongside the datapath
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  typedef logic [15:0] log_tbl_t [LogDepth];

  // shift-subtract divide, used at elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1+x) = 2*atanh(x/(2+x)) in Q0.30, rounded to Q0.16
  function automatic logic [15:0] ln1p_q16(input int unsigned i);
    logic [63:0] z, z2, pw, acc, r;
    z   = udiv(64'(i) << 30, 64'(2 * LogDepth + i));
    z2  = (z * z) >> 30;
    pw  = z;
    acc = z;
    for (int unsigned k = 1; k < 40; k++) begin
      if (pw != 64'd0) begin
        pw  = (pw * z2) >> 30;
        acc = acc + udiv(pw, 64'(2 * k + 1));
      end
    end
    r = ((acc << 1) + 64'd8192) >> 14;
    return r[15:0];
  endfunction

  function automatic log_tbl_t build_log_tbl();
    log_tbl_t t;
    for (int unsigned i = 0; i < LogDepth; i++) begin
      t[i] = ln1p_q16(i);
    end
    return t;
  endfunction

  localparam log_tbl_t LogTbl = build_log_tbl();

endpackage

>>> rtl/core/bpt_lane.sv
// ----------------------------------------------------------------------------
// bpt_lane
// One template lane: registered scale times template product, zero when the
// lane is not in use.
// ----------------------------------------------------------------------------
module bpt_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          use_i,
  input  logic [bpt_pkg::ScaleW-1:0]    scale_i,
  input  logic [bpt_pkg::TplW-1:0]      tpl_i,
  output logic [bpt_pkg::ProdW-1:0]     prod_o
);

  logic [bpt_pkg::ProdW-1:0] prod_q, prod_d;

  always_comb begin
    prod_d = use_i ? (bpt_pkg::ProdW'(scale_i) * bpt_pkg::ProdW'(tpl_i)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/core/bpt_merge.sv
// ----------------------------------------------------------------------------
// bpt_merge
// Sums the lane products, rounds to Q16.8, saturates high and floors at one
// LSB. Registered output.
// ----------------------------------------------------------------------------
module bpt_merge (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic [bpt_pkg::NumTpl-1:0][bpt_pkg::ProdW-1:0] prod_i,
  output logic [bpt_pkg::PredW-1:0]                  pred_o
);

  localparam int unsigned AccW = bpt_pkg::ProdW + $clog2(bpt_pkg::NumTpl + 1);

  logic [AccW-1:0]              acc;
  logic [AccW-1:0]              rnd;
  logic [bpt_pkg::PredW-1:0]    pred_d, pred_q;

  always_comb begin
    acc = '0;
    for (int i = 0; i < bpt_pkg::NumTpl; i++) begin
      acc = acc + AccW'(prod_i[i]);
    end
    rnd = (acc + AccW'(2048)) >> 12;
    if (rnd > AccW'({bpt_pkg::PredW{1'b1}})) begin
      pred_d = '1;
    end else if (rnd == '0) begin
      pred_d = bpt_pkg::PredW'(1);
    end else begin
      pred_d = rnd[bpt_pkg::PredW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pred_q <= pred_d;
    end
  end

  assign pred_o = pred_q;

endmodule

>>> rtl/core/bpt_log.sv
// ----------------------------------------------------------------------------
// bpt_log
// Natural log of the prediction in signed Q.16: leading-one position times
// ln 2 plus a mantissa table entry. Registered output.
// ----------------------------------------------------------------------------
module bpt_log (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [bpt_pkg::PredW-1:0]           pred_i,
  output logic signed [bpt_pkg::LnW-1:0]      ln_o
);

  localparam int unsigned EW = $clog2(bpt_pkg::PredW);

  logic [EW-1:0]                     e;
  logic [bpt_pkg::PredW+bpt_pkg::LogIdxW-1:0] norm;
  logic [bpt_pkg::LogIdxW-1:0]       idx;
  logic signed [EW+1:0]              e_off;
  logic signed [bpt_pkg::LnW-1:0]    ln_d, ln_q;

  always_comb begin
    e = '0;
    for (int k = 0; k < bpt_pkg::PredW; k++) begin
      if (pred_i[k]) begin
        e = EW'(k);
      end
    end
    // leading one lands just above the index bits
    norm  = {pred_i, {bpt_pkg::LogIdxW{1'b0}}} >> e;
    idx   = norm[bpt_pkg::LogIdxW-1:0];
    e_off = $signed({2'b00, e}) - (EW+2)'(8);
    ln_d  = bpt_pkg::LnW'(e_off) * bpt_pkg::LnW'($signed({1'b0, bpt_pkg::Ln2Q16}))
          + $signed({{(bpt_pkg::LnW-16){1'b0}}, bpt_pkg::LogTbl[idx]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ln_q <= ln_d;
    end
  end

  assign ln_o = ln_q;

endmodule

>>> rtl/core/binned_poisson_template_likelihood_top.sv
// ----------------------------------------------------------------------------
// binned_poisson_template_likelihood_top
// Streams histogram bins, accumulates 2*(mu - n*ln mu) and emits the sum on
// the last bin.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid_i/in_stall_o  in_item_i  (bpt_pkg::in_item_t)
// out       output     out_valid_o/out_stall_i out_item_o (bpt_pkg::out_item_t)
// cfg       input      APB psel/penable/pready paddr, pwdata, prdata
//
// One bin at a time: an item passes the lane products, merge, log and term
// registers before it is accumulated, and no new item is accepted until it
// reaches the sum; the pipeline depth sets this.
// in_stall_o is high while a bin is in flight.
// A last bin waits in the term stage while a previous result is still stalled.
// Reset clears the sum, flag, scales (1.0) and templates_used (5).
// ----------------------------------------------------------------------------
module binned_poisson_template_likelihood_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bpt_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bpt_pkg::out_item_t              out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpt_pkg::AddrW-1:0]       paddr,
  input  logic [bpt_pkg::DataW-1:0]       pwdata,
  output logic [bpt_pkg::DataW-1:0]       prdata,
  output logic                            pready
);

  localparam int unsigned TW = 42;

  // configuration
  logic [bpt_pkg::NumTpl-1:0][bpt_pkg::ScaleW-1:0] scale_q;
  logic [bpt_pkg::UsedW-1:0]                       used_q;
  bpt_pkg::reg_idx_e                               reg_idx;
  logic                                            wr_en;
  logic [bpt_pkg::UsedW-1:0]                       used_eff;

  assign pready  = 1'b1;
  assign reg_idx = bpt_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpt_pkg::NumTpl; i++) begin
        scale_q[i] <= bpt_pkg::ScaleRst;
      end
      used_q <= bpt_pkg::UsedRst;
    end else if (wr_en) begin
      case (reg_idx)
        bpt_pkg::RegScale0: scale_q[0] <= pwdata[bpt_pkg::ScaleW-1:0];
        bpt_pkg::RegScale1: scale_q[1] <= pwdata[bpt_pkg::ScaleW-1:0];
        bpt_pkg::RegScale2: scale_q[2] <= pwdata[bpt_pkg::ScaleW-1:0];
        bpt_pkg::RegScale3: scale_q[3] <= pwdata[bpt_pkg::ScaleW-1:0];
        bpt_pkg::RegScale4: scale_q[4] <= pwdata[bpt_pkg::ScaleW-1:0];
        bpt_pkg::RegUsed:   used_q     <= pwdata[bpt_pkg::UsedW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpt_pkg::RegScale0: prdata = bpt_pkg::DataW'(scale_q[0]);
      bpt_pkg::RegScale1: prdata = bpt_pkg::DataW'(scale_q[1]);
      bpt_pkg::RegScale2: prdata = bpt_pkg::DataW'(scale_q[2]);
      bpt_pkg::RegScale3: prdata = bpt_pkg::DataW'(scale_q[3]);
      bpt_pkg::RegScale4: prdata = bpt_pkg::DataW'(scale_q[4]);
      bpt_pkg::RegUsed:   prdata = bpt_pkg::DataW'(used_q);
      default:            prdata = '0;
    endcase
  end

  assign used_eff = (used_q > bpt_pkg::UsedW'(bpt_pkg::NumTpl))
                  ? bpt_pkg::UsedW'(bpt_pkg::NumTpl) : used_q;

  // pipeline control
  logic                    accept, done, busy_q, busy_d;
  bpt_pkg::stage_ctl_t     c1_q, c2_q, c3_q, c4_q;
  logic [bpt_pkg::CountW-1:0] n1_q, n2_q, n3_q;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign done       = c4_q.valid && !(c4_q.last && out_valid_o && out_stall_i);

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      c1_q   <= '0;
      c2_q   <= '0;
      c3_q   <= '0;
      c4_q   <= '0;
    end else begin
      busy_q     <= busy_d;
      c1_q.valid <= accept;
      c1_q.last  <= in_item_i.last_bin;
      c2_q       <= c1_q;
      c3_q       <= c2_q;
      if (c3_q.valid) begin
        c4_q <= c3_q;
      end else if (done) begin
        c4_q.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n1_q <= in_item_i.observed_count;
    end
    n2_q <= n1_q;
    n3_q <= n2_q;
  end

  // lanes
  logic [bpt_pkg::NumTpl-1:0][bpt_pkg::TplW-1:0]  tpl;
  logic [bpt_pkg::NumTpl-1:0][bpt_pkg::ProdW-1:0] prod;

  assign tpl[0] = in_item_i.template_0;
  assign tpl[1] = in_item_i.template_1;
  assign tpl[2] = in_item_i.template_2;
  assign tpl[3] = in_item_i.template_3;
  assign tpl[4] = in_item_i.template_4;

  for (genvar g = 0; g < bpt_pkg::NumTpl; g++) begin : g_lane
    bpt_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (accept),
      .use_i   (used_eff > bpt_pkg::UsedW'(g)),
      .scale_i (scale_q[g]),
      .tpl_i   (tpl[g]),
      .prod_o  (prod[g])
    );
  end

  logic [bpt_pkg::PredW-1:0]        pred2, pred3_q;
  logic signed [bpt_pkg::LnW-1:0]   ln3;

  bpt_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (c1_q.valid),
    .prod_i (prod),
    .pred_o (pred2)
  );

  bpt_log u_log (
    .clk_i  (clk_i),
    .en_i   (c2_q.valid),
    .pred_i (pred2),
    .ln_o   (ln3)
  );

  always_ff @(posedge clk_i) begin
    if (c2_q.valid) begin
      pred3_q <= pred2;
    end
  end

  // term: 2*(p*256 - n*ln) rounded to Q.8
  logic signed [TW-1:0]               nln, t, t2;
  logic signed [bpt_pkg::AddW-1:0]    add_d, add_q;

  always_comb begin
    nln   = TW'($signed({1'b0, n3_q})) * TW'(ln3);
    t     = $signed(TW'({pred3_q, 8'd0})) - nln;
    t2    = (t <<< 1) + TW'(128);
    add_d = bpt_pkg::AddW'(t2 >>> 8);
  end

  always_ff @(posedge clk_i) begin
    if (c3_q.valid) begin
      add_q <= add_d;
    end
  end

  // accumulate
  logic signed [bpt_pkg::SumW-1:0] sum_q, sum_sat;
  logic signed [bpt_pkg::SumW:0]   sum_ext;
  logic                            ovf_q, ovf_now;
  logic                            out_valid_q;
  bpt_pkg::out_item_t              out_q;

  always_comb begin
    sum_ext = $signed({sum_q[bpt_pkg::SumW-1], sum_q})
            + (bpt_pkg::SumW+1)'(add_q);
    ovf_now = sum_ext[bpt_pkg::SumW] != sum_ext[bpt_pkg::SumW-1];
    if (!ovf_now) begin
      sum_sat = sum_ext[bpt_pkg::SumW-1:0];
    end else if (sum_ext[bpt_pkg::SumW]) begin
      sum_sat = {1'b1, {(bpt_pkg::SumW-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(bpt_pkg::SumW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (done) begin
        if (c4_q.last) begin
          sum_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          sum_q <= sum_sat;
          ovf_q <= ovf_q || ovf_now;
        end
      end
      if (done && c4_q.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && c4_q.last) begin
      out_q.deviance  <= sum_sat;
      out_q.saturated <= ovf_q || ovf_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> rtl/core/bpt_checker.sv
// ----------------------------------------------------------------------------
// bpt_checker
// Port-level checks on the likelihood block, bound to the top level.
// ----------------------------------------------------------------------------
module bpt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bpt_pkg::out_item_t out_item_o,
  input logic               pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // one bin in flight: an accepted item blocks the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after accept");

  // a new result needs a bin in flight the cycle before
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a bin in flight");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind binned_poisson_template_likelihood_top bpt_checker u_bpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);

>>> sim/binned_poisson_template_likelihood_top_test.sv
// ----------------------------------------------------------------------------
// binned_poisson_template_likelihood_top_test
// Streams histogram bins through the deviance accumulator under random
// sender gaps and receiver stalls. Each bin is run through a local model of
// the prediction, ln lookup and saturating sum; emitted sums are checked
// in order against it. Scales and the template count are changed between
// histograms through the APB port.
// ----------------------------------------------------------------------------
module binned_poisson_template_likelihood_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 20;

  class deviance_scoreboard;
    logic [15:0] scale_q[bpt_pkg::NumTpl];
    int unsigned used_n;
    logic signed [bpt_pkg::SumW-1:0] sum_q;
    bit sat_q;
    bpt_pkg::out_item_t pending_q[$];
    logic [15:0] ln_mant[bpt_pkg::LogDepth];
    int unsigned n_fail;
    int unsigned n_sums;
    int unsigned n_sat;

    function logic [15:0] ln1p(int unsigned i);
      longint unsigned z, z2, pw, acc;
      z   = (longint'(i) << 30) / longint'(2 * bpt_pkg::LogDepth + i);
      z2  = (z * z) >> 30;
      pw  = z;
      acc = z;
      for (int unsigned k = 1; k < 40 && pw != 0; k++) begin
        pw  = (pw * z2) >> 30;
        acc += pw / (2 * k + 1);
      end
      return 16'((2 * acc + 8192) >> 14);
    endfunction

    function void clear();
      for (int i = 0; i < bpt_pkg::LogDepth; i++) ln_mant[i] = ln1p(i);
      for (int i = 0; i < bpt_pkg::NumTpl; i++) scale_q[i] = 16'd4096;
      used_n = 5;
      sum_q  = '0;
      sat_q  = 1'b0;
      n_fail = 0;
      n_sums = 0;
      n_sat  = 0;
    endfunction

    function void write_reg(bpt_pkg::reg_idx_e idx, logic [31:0] v);
      if (idx == bpt_pkg::RegUsed) used_n = v[2:0];
      else scale_q[idx] = v[15:0];
    endfunction

    function longint ln_of(longint unsigned p);
      int e;
      longint unsigned idx;
      e = 23;
      while (e > 0 && p[e] == 1'b0) e--;
      idx = ((p - (64'd1 << e)) * bpt_pkg::LogDepth) >> e;
      if (idx >= bpt_pkg::LogDepth) idx = bpt_pkg::LogDepth - 1;
      return longint'(e - 8) * 45426 + longint'(ln_mant[idx]);
    endfunction

    function void note_bin(bpt_pkg::in_item_t b);
      logic [bpt_pkg::TplW-1:0] tpl[bpt_pkg::NumTpl];
      longint unsigned acc, pred;
      longint t, add, s;
      int unsigned cnt;
      logic signed [63:0] lim_hi, lim_lo;
      bpt_pkg::out_item_t r;
      tpl = '{b.template_0, b.template_1, b.template_2, b.template_3, b.template_4};
      cnt = (used_n > bpt_pkg::NumTpl) ? bpt_pkg::NumTpl : used_n;
      acc = 0;
      for (int i = 0; i < cnt; i++) acc += longint'(scale_q[i]) * longint'(tpl[i]);
      pred = (acc + 2048) >> 12;
      if (pred > 64'hFF_FFFF) pred = 64'hFF_FFFF;
      if (pred < 1) pred = 1;
      t   = longint'(pred << 8) - longint'(b.observed_count) * ln_of(pred);
      add = (2 * t + 128) >>> 8;
      lim_hi = (64'sd1 <<< 55) - 1;
      lim_lo = -(64'sd1 <<< 55);
      s = longint'(sum_q) + add;
      if (s > lim_hi) begin
        s = lim_hi;
        sat_q = 1'b1;
      end else if (s < lim_lo) begin
        s = lim_lo;
        sat_q = 1'b1;
      end
      sum_q = s[bpt_pkg::SumW-1:0];
      if (b.last_bin) begin
        r.deviance  = sum_q;
        r.saturated = sat_q;
        pending_q.push_back(r);
        sum_q = '0;
        sat_q = 1'b0;
      end
    endfunction

    function void check_sum(bpt_pkg::out_item_t got);
      bpt_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result deviance=%0d", got.deviance);
        n_fail++;
        return;
      end
      want = pending_q.pop_front();
      n_sums++;
      if (got.saturated) n_sat++;
      if (got.deviance !== want.deviance) begin
        $error("deviance: expected %0d, actual %0d", want.deviance, got.deviance);
        n_fail++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        n_fail++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bpt_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bpt_pkg::out_item_t out_item_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bpt_pkg::AddrW-1:0] paddr = '0;
  logic [bpt_pkg::DataW-1:0] pwdata = '0;
  logic [bpt_pkg::DataW-1:0] prdata;
  logic pready;

  deviance_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  bit stall_mode = 1'b0;

  binned_poisson_template_likelihood_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall: alternates between free-running and heavily stalled spans
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
    out_stall_i <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_sum(out_item_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // the bus goes idle after each write before the task returns
  task automatic apb_write(bpt_pkg::reg_idx_e idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bpt_pkg::AddrW'(4 * idx);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // gaps: callers pass gap probability; none when zero
  // valid stays high after an accept until the next item, a gap or a drain
  task automatic send_bin(bpt_pkg::in_item_t b, int unsigned gap_pct);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_bin(b);
  endtask

  function automatic logic [bpt_pkg::TplW-1:0] rand_tpl();
    case ($urandom_range(0, 3))
      0: return bpt_pkg::TplW'($urandom_range(0, 4096));
      1: return bpt_pkg::TplW'($urandom);
      2: return {bpt_pkg::TplW{1'b1}};
      default: return bpt_pkg::TplW'($urandom_range(0, 1 << 16));
    endcase
  endfunction

  function automatic bpt_pkg::in_item_t rand_bin(bit last);
    bpt_pkg::in_item_t b;
    b.observed_count = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, 300));
    b.template_0 = rand_tpl();
    b.template_1 = rand_tpl();
    b.template_2 = rand_tpl();
    b.template_3 = rand_tpl();
    b.template_4 = rand_tpl();
    b.last_bin   = last;
    return b;
  endfunction

  task automatic config_random();
    for (int i = 0; i < bpt_pkg::NumTpl; i++) begin
      case ($urandom_range(0, 4))
        0: apb_write(bpt_pkg::reg_idx_e'(i), 32'd0);
        1: apb_write(bpt_pkg::reg_idx_e'(i), 32'hFFFF);
        default: apb_write(bpt_pkg::reg_idx_e'(i), $urandom);
      endcase
    end
    apb_write(bpt_pkg::RegUsed, $urandom_range(0, 7));
  endtask

  initial begin
    bpt_pkg::in_item_t b;
    int unsigned sent, gap_pct, hist_len;
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes with reset config, zero and oversize template counts
    b = '0;
    b.last_bin = 1'b1;
    send_bin(b, 0);
    b = '1;
    send_bin(b, 0);
    b = '1;
    b.observed_count = '0;
    send_bin(b, 0);
    b = '1;
    b.last_bin = 1'b0;
    for (int i = 0; i < 6; i++) send_bin(b, 0);
    b.observed_count = '0;
    b.last_bin = 1'b1;
    send_bin(b, 0);
    wait_drained();
    for (int i = 0; i < bpt_pkg::NumTpl; i++) apb_write(bpt_pkg::reg_idx_e'(i), 32'hFFFF);
    apb_write(bpt_pkg::RegUsed, 32'd7);
    b = '1;
    b.observed_count = '0;
    b.last_bin = 1'b0;
    for (int i = 0; i < 4; i++) send_bin(b, 0);
    b.last_bin = 1'b1;
    send_bin(b, 0);
    wait_drained();
    apb_write(bpt_pkg::RegUsed, 32'd0);
    b = rand_bin(1'b1);
    b.observed_count = 16'hFFFF;
    send_bin(b, 0);
    b = rand_bin(1'b1);
    send_bin(b, 0);
    wait_drained();
    for (int i = 0; i < bpt_pkg::NumTpl; i++) apb_write(bpt_pkg::reg_idx_e'(i), 32'd0);
    apb_write(bpt_pkg::RegUsed, 32'd1);
    send_bin(rand_bin(1'b1), 0);
    wait_drained();
    apb_write(bpt_pkg::RegUsed, 32'd5);
    for (int i = 0; i < bpt_pkg::NumTpl; i++) apb_write(bpt_pkg::reg_idx_e'(i), 32'd4096);

    // random histograms, config changes between some of them
    sent = 0;
    while (sent < 750) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_drained();
        config_random();
      end
      hist_len = $urandom_range(1, 20);
      gap_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      for (int i = 0; i < hist_len; i++) begin
        send_bin(rand_bin(i == hist_len - 1), gap_pct);
        sent++;
      end
    end

    wait_drained();
    $display("covered %0d histogram sums, %0d of them saturated, over random scales",
             sb.n_sums, sb.n_sat);
    $display("and template counts 0..7 with sender gaps and receiver stalls");
    if (sb.n_fail == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
